// ===== rtl/md5pm_pkg.sv =====
// Package for the MD5 PIN match block: widths, MD5 constants, round helpers.
// Used by every module in rtl/; depends on nothing.
package md5pm_pkg;

	localparam int PinDigits = 6;
	localparam int PinW      = 20;
	localparam int DigW      = 4;
	localparam int CfgW      = 64;
	localparam int IdxW      = 1;
	localparam int Rounds    = 64;
	localparam int MsgBits   = PinDigits * 8;

	// Register indexes
	localparam logic [IdxW-1:0] RegTargetHigh = 1'b0;
	localparam logic [IdxW-1:0] RegTargetLow  = 1'b1;

	localparam logic [7:0] AsciiZero = 8'h30;

	localparam logic [31:0] InitA = 32'h67452301;
	localparam logic [31:0] InitB = 32'hefcdab89;
	localparam logic [31:0] InitC = 32'h98badcfe;
	localparam logic [31:0] InitD = 32'h10325476;

	typedef logic [PinDigits-1:0][DigW-1:0] digits_t;
	typedef logic [15:0][31:0] block_t;

	typedef struct packed {
		logic [31:0] a;
		logic [31:0] b;
		logic [31:0] c;
		logic [31:0] d;
	} md5_state_t;

	function automatic logic [31:0] md5_k(input logic [5:0] i);
		logic [31:0] k;
		begin
			unique case (i)
				6'd0:  k = 32'hd76aa478; 6'd1:  k = 32'he8c7b756;
				6'd2:  k = 32'h242070db; 6'd3:  k = 32'hc1bdceee;
				6'd4:  k = 32'hf57c0faf; 6'd5:  k = 32'h4787c62a;
				6'd6:  k = 32'ha8304613; 6'd7:  k = 32'hfd469501;
				6'd8:  k = 32'h698098d8; 6'd9:  k = 32'h8b44f7af;
				6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
				6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193;
				6'd14: k = 32'ha679438e; 6'd15: k = 32'h49b40821;
				6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
				6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa;
				6'd20: k = 32'hd62f105d; 6'd21: k = 32'h02441453;
				6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
				6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6;
				6'd26: k = 32'hf4d50d87; 6'd27: k = 32'h455a14ed;
				6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
				6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a;
				6'd32: k = 32'hfffa3942; 6'd33: k = 32'h8771f681;
				6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
				6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9;
				6'd38: k = 32'hf6bb4b60; 6'd39: k = 32'hbebfbc70;
				6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
				6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05;
				6'd44: k = 32'hd9d4d039; 6'd45: k = 32'he6db99e5;
				6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
				6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97;
				6'd50: k = 32'hab9423a7; 6'd51: k = 32'hfc93a039;
				6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
				6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1;
				6'd56: k = 32'h6fa87e4f; 6'd57: k = 32'hfe2ce6e0;
				6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
				6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235;
				6'd62: k = 32'h2ad7d2bb; 6'd63: k = 32'heb86d391;
				default: k = 32'h0;
			endcase
			return k;
		end
	endfunction

	function automatic logic [4:0] md5_rot(input logic [5:0] i);
		logic [3:0] sel;
		logic [4:0] s;
		begin
			sel = {i[5:4], i[1:0]};
			unique case (sel)
				4'd0: s = 5'd7;   4'd1: s = 5'd12;  4'd2: s = 5'd17;  4'd3: s = 5'd22;
				4'd4: s = 5'd5;   4'd5: s = 5'd9;   4'd6: s = 5'd14;  4'd7: s = 5'd20;
				4'd8: s = 5'd4;   4'd9: s = 5'd11;  4'd10: s = 5'd16; 4'd11: s = 5'd23;
				4'd12: s = 5'd6;  4'd13: s = 5'd10; 4'd14: s = 5'd15; 4'd15: s = 5'd21;
				default: s = 5'd0;
			endcase
			return s;
		end
	endfunction

	// Message word index used by round i
	function automatic logic [3:0] md5_g(input logic [5:0] i);
		logic [3:0] g;
		logic [7:0] t;
		begin
			unique case (i[5:4])
				2'd0: g = i[3:0];
				2'd1: begin
					t = 8'd5 * {2'b0, i} + 8'd1;
					g = t[3:0];
				end
				2'd2: begin
					t = 8'd3 * {2'b0, i} + 8'd5;
					g = t[3:0];
				end
				default: begin
					t = 8'd7 * {2'b0, i};
					g = t[3:0];
				end
			endcase
			return g;
		end
	endfunction

	function automatic logic [31:0] rotl(input logic [31:0] x, input logic [4:0] s);
		logic [63:0] t;
		begin
			t = {x, x} << s;
			return t[63:32];
		end
	endfunction

	// Swap byte order of a digest word
	function automatic logic [31:0] bswap(input logic [31:0] x);
		return {x[7:0], x[15:8], x[23:16], x[31:24]};
	endfunction

endpackage

// ===== rtl/md5pm_if.sv =====
// Valid/ready channel interfaces for the MD5 PIN match block.
// Depends on md5pm_pkg.
interface md5pm_in_if;
	logic                         valid;
	logic                         ready;
	logic [md5pm_pkg::PinW-1:0]   candidate_pin;
	modport source (output valid, candidate_pin, input ready);
	modport sink   (input valid, candidate_pin, output ready);
endinterface

interface md5pm_out_if;
	logic                         valid;
	logic                         ready;
	logic                         matched;
	logic [md5pm_pkg::PinW-1:0]   tested_pin;
	modport source (output valid, matched, tested_pin, input ready);
	modport sink   (input valid, matched, tested_pin, output ready);
endinterface

// ===== rtl/md5pm_digits.sv =====
// Decimal digit extraction pipeline: one digit per stage, low digit first.
// Depends on md5pm_pkg.
module md5pm_digits (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              adv,
	input  logic                              in_valid,
	input  logic [md5pm_pkg::PinW-1:0]        in_pin,
	output logic                              out_valid,
	output logic [md5pm_pkg::PinW-1:0]        out_pin,
	output md5pm_pkg::digits_t                out_digits
);
	localparam int N = md5pm_pkg::PinDigits;
	localparam int W = md5pm_pkg::PinW;

	logic [N:0]                 vld_s;
	logic [N:0][W-1:0]          rem_s;
	logic [N:0][W-1:0]          pin_s;
	md5pm_pkg::digits_t         dig_s [N+1];

	assign vld_s[0] = in_valid;
	assign rem_s[0] = in_pin;
	assign pin_s[0] = in_pin;
	assign dig_s[0] = '0;

	// Peel one decimal digit per stage: quotient by reciprocal multiply, then fix
	for (genvar i = 0; i < N; i++) begin : g_dig
		logic [2*W+3:0] prod;
		logic [W-1:0]   q0;
		logic [W+3:0]   r0;
		logic [W-1:0]   q;
		logic [3:0]     r;
		md5pm_pkg::digits_t dnext;
		always_comb begin
			prod = (W+4+W)'(rem_s[i]) * (W+4+W)'(24'hCCCCD);
			q0   = W'(prod >> 23);
			r0   = (W+4)'(rem_s[i]) - (W+4)'(q0) * (W+4)'(10);
			if (r0 >= (W+4)'(10)) begin
				q = q0 + W'(1);
				r = 4'(r0 - (W+4)'(10));
			end else begin
				q = q0;
				r = r0[3:0];
			end
			// Insert this stage's digit into the string carried along
			dnext          = dig_s[i];
			dnext[N-1-i]   = r;
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i+1] <= 1'b0;
			end else if (adv) begin
				vld_s[i+1] <= vld_s[i];
			end
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				rem_s[i+1] <= q;
				pin_s[i+1] <= pin_s[i];
				dig_s[i+1] <= dnext;
			end
		end
	end

	assign out_valid  = vld_s[N];
	assign out_pin    = pin_s[N];
	assign out_digits = dig_s[N];
endmodule

// ===== rtl/md5pm_round.sv =====
// 64-round MD5 compression pipeline, two register stages per round.
// Depends on md5pm_pkg.
module md5pm_round (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              adv,
	input  logic                              in_valid,
	input  logic [md5pm_pkg::PinW-1:0]        in_pin,
	input  md5pm_pkg::digits_t                in_digits,
	output logic                              out_valid,
	output logic [md5pm_pkg::PinW-1:0]        out_pin,
	output md5pm_pkg::md5_state_t             out_state
);
	localparam int R = md5pm_pkg::Rounds;
	localparam int N = md5pm_pkg::PinDigits;

	md5pm_pkg::block_t      blk;
	logic [R:0]             vld_s;
	logic [R:0][md5pm_pkg::PinW-1:0] pin_s;
	md5pm_pkg::digits_t     dig_s [R+1];
	md5pm_pkg::md5_state_t  st_s  [R+1];

	// Build the padded block from the digit string of this stage
	function automatic md5pm_pkg::block_t mk_block(input md5pm_pkg::digits_t d);
		logic [63:0][7:0] b;
		logic [63:0]      bits;
		md5pm_pkg::block_t w;
		begin
			b = '0;
			for (int j = 0; j < N; j++)
				b[j] = md5pm_pkg::AsciiZero + {4'b0, d[j]};
			b[N] = 8'h80;
			bits = 64'(md5pm_pkg::MsgBits);
			for (int j = 0; j < 8; j++)
				b[56+j] = bits[8*j +: 8];
			for (int j = 0; j < 16; j++)
				w[j] = {b[4*j+3], b[4*j+2], b[4*j+1], b[4*j]};
			return w;
		end
	endfunction

	assign vld_s[0] = in_valid;
	assign pin_s[0] = in_pin;
	assign dig_s[0] = in_digits;
	assign st_s[0]  = '{a: md5pm_pkg::InitA, b: md5pm_pkg::InitB,
	                   c: md5pm_pkg::InitC, d: md5pm_pkg::InitD};
	assign blk = '0;

	for (genvar i = 0; i < R; i++) begin : g_rnd
		localparam logic [5:0] RI = 6'(i);
		md5pm_pkg::block_t w;
		logic [31:0] f, sum;
		logic [31:0] sum_s;
		logic        v_h;
		logic [md5pm_pkg::PinW-1:0] p_h;
		md5pm_pkg::digits_t d_h;
		md5pm_pkg::md5_state_t st_h;
		md5pm_pkg::md5_state_t nxt;

		// First half: round function and additions
		always_comb begin
			w = mk_block(dig_s[i]);
			unique case (RI[5:4])
				2'd0: f = (st_s[i].b & st_s[i].c) | (~st_s[i].b & st_s[i].d);
				2'd1: f = (st_s[i].d & st_s[i].b) | (~st_s[i].d & st_s[i].c);
				2'd2: f = st_s[i].b ^ st_s[i].c ^ st_s[i].d;
				default: f = st_s[i].c ^ (st_s[i].b | ~st_s[i].d);
			endcase
			sum = st_s[i].a + f + md5pm_pkg::md5_k(RI) + w[md5pm_pkg::md5_g(RI)];
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_h        <= 1'b0;
				vld_s[i+1] <= 1'b0;
			end else if (adv) begin
				v_h        <= vld_s[i];
				vld_s[i+1] <= v_h;
			end
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				sum_s <= sum;
				p_h   <= pin_s[i];
				d_h   <= dig_s[i];
				st_h  <= st_s[i];
			end
		end
		// Second half: rotate, add and shift the state words
		always_comb begin
			nxt.a = st_h.d;
			nxt.d = st_h.c;
			nxt.c = st_h.b;
			nxt.b = st_h.b + md5pm_pkg::rotl(sum_s, md5pm_pkg::md5_rot(RI));
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				st_s[i+1]  <= nxt;
				pin_s[i+1] <= p_h;
				dig_s[i+1] <= d_h;
			end
		end
	end

	assign out_valid = vld_s[R] & ~|blk;
	assign out_pin   = pin_s[R];
	assign out_state = st_s[R];
endmodule

// ===== rtl/md5_pin_match_top.sv =====
// Top level of the MD5 PIN match block: config registers, pipeline, compare.
// Depends on md5pm_pkg, md5pm_if, md5pm_digits and md5pm_round.

// One candidate is accepted per clock unless stalled; its result passes
// through six digit-extraction stages, 128 stages for the 64 MD5 rounds (two
// per round) and two for the final add and digest compare. The whole pipeline
// advances together; it stalls only while a result waits at the output and
// the sink is not ready. Write the target digest only while the block is idle.
module md5_pin_match_top (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [md5pm_pkg::IdxW-1:0]          cfg_index,
	input  logic [md5pm_pkg::CfgW-1:0]          cfg_data,
	md5pm_in_if.sink                            in_ch,
	md5pm_out_if.source                         out_ch
);
	logic [md5pm_pkg::CfgW-1:0] tgt_hi_q, tgt_lo_q;
	logic adv;
	logic d_valid, r_valid;
	logic [md5pm_pkg::PinW-1:0] d_pin, r_pin;
	md5pm_pkg::digits_t d_digits;
	md5pm_pkg::md5_state_t r_state;
	logic [127:0] dig_s1;
	logic         v_s1;
	logic [md5pm_pkg::PinW-1:0] pin_s1;
	logic         v_s2, m_s2;
	logic [md5pm_pkg::PinW-1:0] pin_s2;

	// Advance unless the output holds a result that is not taken
	assign adv         = !v_s2 || out_ch.ready;
	assign in_ch.ready = adv;

	// Target digest registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tgt_hi_q <= '0;
			tgt_lo_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				md5pm_pkg::RegTargetHigh: tgt_hi_q <= cfg_data;
				md5pm_pkg::RegTargetLow:  tgt_lo_q <= cfg_data;
				default: ;
			endcase
		end
	end

	md5pm_digits u_digits (
		.clk, .arst_n, .adv,
		.in_valid(in_ch.valid && in_ch.ready),
		.in_pin(in_ch.candidate_pin),
		.out_valid(d_valid), .out_pin(d_pin), .out_digits(d_digits)
	);

	md5pm_round u_round (
		.clk, .arst_n, .adv,
		.in_valid(d_valid), .in_pin(d_pin), .in_digits(d_digits),
		.out_valid(r_valid), .out_pin(r_pin), .out_state(r_state)
	);

	// Final add and byte order
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s1 <= r_valid;
			v_s2 <= v_s1;
		end
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			dig_s1 <= {md5pm_pkg::bswap(md5pm_pkg::InitA + r_state.a),
			           md5pm_pkg::bswap(md5pm_pkg::InitB + r_state.b),
			           md5pm_pkg::bswap(md5pm_pkg::InitC + r_state.c),
			           md5pm_pkg::bswap(md5pm_pkg::InitD + r_state.d)};
			pin_s1 <= r_pin;
			m_s2   <= (dig_s1 == {tgt_hi_q, tgt_lo_q});
			pin_s2 <= pin_s1;
		end
	end

	assign out_ch.valid      = v_s2;
	assign out_ch.matched    = m_s2;
	assign out_ch.tested_pin = pin_s2;

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 && !out_ch.ready |=> v_s2 && $stable(pin_s2) && $stable(m_s2))
		else $error("result changed while stalled");
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!v_s2 |-> in_ch.ready)
		else $error("input blocked with empty output");
	a_move: assert property (@(posedge clk) disable iff (!arst_n)
		adv && v_s1 |=> v_s2)
		else $error("result lost at output stage");
endmodule
